// ----- design/des_pkg.sv -----
// ---------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and helper functions for the DES pipeline.
// ---------------------------------------------------------------------------
package des_pkg;

	localparam int Rounds = 16;

	typedef logic [63:0] blk_t;
	typedef logic [47:0] subkey_t;
	typedef logic [55:0] cd_t;

	typedef enum logic {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} cmd_t;

	typedef logic [7:0] tab_entry_t;

	localparam tab_entry_t TAB_IP [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam tab_entry_t TAB_FP [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam tab_entry_t TAB_E [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

	localparam tab_entry_t TAB_P [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

	localparam tab_entry_t TAB_PC1 [56] = '{
		57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
		10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

	localparam tab_entry_t TAB_PC2 [48] = '{
		14,17,11,24,1,5,   3,28,15,6,21,10,
		23,19,12,4,26,8,   16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48,
		44,49,39,56,34,53, 46,42,50,36,29,32};

	localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	localparam logic [3:0] TAB_S [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Table bit 1 is the most significant bit of the vector.
	function automatic blk_t perm_ip(blk_t v);
		blk_t r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TAB_IP[i])];
		return r;
	endfunction

	function automatic blk_t perm_fp(blk_t v);
		blk_t r;
		for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TAB_FP[i])];
		return r;
	endfunction

	function automatic cd_t perm_pc1(blk_t v);
		cd_t r;
		for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TAB_PC1[i])];
		return r;
	endfunction

	function automatic subkey_t perm_pc2(cd_t v);
		subkey_t r;
		for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TAB_PC2[i])];
		return r;
	endfunction

	function automatic logic [27:0] rotl28(logic [27:0] x, logic [1:0] s);
		return (s == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
	endfunction

	function automatic logic [31:0] feistel(logic [31:0] r, subkey_t k);
		logic [47:0] x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0]  b;
		for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TAB_E[i])];
		x = x ^ k;
		for (int i = 0; i < 8; i++) begin
			b = x[47-6*i -: 6];
			s[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TAB_P[i])];
		return p;
	endfunction

endpackage

// ----- design/des_block_cipher_top.sv -----
// ---------------------------------------------------------------------------
// DES block cipher top level
// Sixteen-round DES encrypt/decrypt pipeline with one round per stage.
// ---------------------------------------------------------------------------
// One 64-bit block enters per cycle unless a stalled result waits at the
// output. The initial permutation is registered at the accepting edge, and
// each of the sixteen Feistel rounds adds one more stage. Subkeys are derived
// from the key register once after each key write and held in registers.
// The key may be written only while the pipeline is empty. A stall at the
// output while a result is valid freezes all stages.
module des_block_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data
);
	import des_pkg::*;

	logic [63:0] key_q;
	subkey_t     sk_q [Rounds];
	subkey_t     sk_d [Rounds];
	cd_t         pc1_d;
	blk_t        ip_d;
	logic        adv;

	logic        v_s   [Rounds+1];
	logic        dec_s [Rounds+1];
	logic [31:0] l_s   [Rounds+1];
	logic [31:0] r_s   [Rounds+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_q <= '0;
		else if (cfg_valid) key_q <= cfg_data;
	end

	// Subkey schedule is pure function of the key; registered for timing.
	assign pc1_d = perm_pc1(key_q);

	always_comb begin
		logic [27:0] c;
		logic [27:0] d;
		c = pc1_d[55:28];
		d = pc1_d[27:0];
		for (int i = 0; i < Rounds; i++) begin
			c = rotl28(c, TAB_ROT[i]);
			d = rotl28(d, TAB_ROT[i]);
			sk_d[i] = perm_pc2({c, d});
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Rounds; i++) sk_q[i] <= sk_d[i];
	end

	// The whole pipeline moves unless a finished result waits at the output.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign ip_d = perm_ip(block_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Rounds; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= Rounds; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s[0] <= cmd;
			l_s[0]   <= ip_d[63:32];
			r_s[0]   <= ip_d[31:0];
			for (int i = 1; i <= Rounds; i++) begin
				dec_s[i] <= dec_s[i-1];
				l_s[i]   <= r_s[i-1];
				r_s[i]   <= l_s[i-1] ^ feistel(r_s[i-1],
					(dec_s[i-1] == CMD_DECRYPT) ? sk_q[Rounds-i] : sk_q[i-1]);
			end
		end
	end

	assign out_valid = v_s[Rounds];
	assign block_out = perm_fp({r_s[Rounds], l_s[Rounds]});

endmodule

// ----- design/des_checker.sv -----
// ---------------------------------------------------------------------------
// DES port checker
// Watches the top-level ports for pipeline ordering and handshake rules.
// ---------------------------------------------------------------------------
module des_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] block_out
);
	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_out))
		else $error("result changed under stall");

	// The input is stalled only while the output is stalled.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// A waiting result always holds off the input.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input open while a result waits");

	// Without stalls, no result is valid unless a block was accepted before it.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !out_stall |-> ##17 (!out_valid || $past(out_stall, 1) ||
			$past(out_stall, 2) || $past(out_stall, 3) || $past(out_stall, 4) ||
			$past(out_stall, 5) || $past(out_stall, 6) || $past(out_stall, 7) ||
			$past(out_stall, 8) || $past(out_stall, 9) || $past(out_stall, 10) ||
			$past(out_stall, 11) || $past(out_stall, 12) || $past(out_stall, 13) ||
			$past(out_stall, 14) || $past(out_stall, 15) || $past(out_stall, 16)))
		else $error("result without request");
endmodule

bind des_block_cipher_top des_checker u_des_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .block_out(block_out));
